// ===== rtl/i2ctb_pkg.sv =====
// shared types, constants and codes of the i2c target buffer engine
`default_nettype none

package i2ctb_pkg;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;
  localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RX_CW    = $clog2(RX_DEPTH + 1);
  localparam int TX_CW    = $clog2(TX_DEPTH + 1);

  localparam int Q_DEPTH  = 4;
  localparam int Q_AW     = $clog2(Q_DEPTH);
  localparam int Q_CW     = $clog2(Q_DEPTH + 1);

  localparam int CFG_IW   = 1;
  localparam int CFG_DW   = 1;

  localparam logic [7:0] BYTE_EXHAUSTED = 8'hFF;

  typedef enum logic [3:0] {
    MODE_WR_ADDR = 4'd0,
    MODE_RX_ACK  = 4'd1,
    MODE_RX_NACK = 4'd2,
    MODE_STOP    = 4'd3,
    MODE_RD_ADDR = 4'd4,
    MODE_TX_ACK  = 4'd5,
    MODE_TX_NACK = 4'd6,
    MODE_BUS_ERR = 4'd7,
    MODE_OTHER   = 4'd8,
    MODE_LOAD    = 4'd9,
    MODE_COMMIT  = 4'd10,
    MODE_HOST_RD = 4'd11,
    MODE_RELEASE = 4'd12
  } mode_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_RX_NOTIFY_EN = 1'd0,
    CFG_TX_NOTIFY_EN = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_ACTIVE = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] bus_byte;
    logic [5:0] host_index;
    logic [7:0] host_byte;
    logic [7:0] host_length;
  } in_item_t;

  typedef struct packed {
    logic       ack_next;
    logic [7:0] drive_byte;
    logic       rx_done;
    logic       tx_done;
    logic [6:0] rx_count;
    logic [6:0] tx_count;
    logic [7:0] host_data;
    logic       length_fit;
    logic       rx_notify;
    logic       tx_notify;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;
  } cfg_wr_t;

  // partial result handed from front to back, store read data merged later
  typedef struct packed {
    logic      sel_rx;
    logic      sel_tx;
    out_item_t res;
  } stage_t;

endpackage

`default_nettype wire

// ===== rtl/i2ctb_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module i2ctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic                                          re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2ctb_front.sv =====
// front end: accepts requests, updates buffer state, issues store accesses
`default_nettype none

module i2ctb_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire i2ctb_pkg::in_item_t in_item,
  input  wire i2ctb_pkg::cfg_wr_t  cfg_wr,
  output logic                     rx_we,
  output logic [i2ctb_pkg::RX_AW-1:0] rx_waddr,
  output logic [7:0]               rx_wdata,
  output logic                     rx_re,
  output logic [i2ctb_pkg::RX_AW-1:0] rx_raddr,
  output logic                     tx_we,
  output logic [i2ctb_pkg::TX_AW-1:0] tx_waddr,
  output logic [7:0]               tx_wdata,
  output logic                     tx_re,
  output logic [i2ctb_pkg::TX_AW-1:0] tx_raddr,
  output logic                     stage_valid,
  output i2ctb_pkg::stage_t        stage
);

  import i2ctb_pkg::*;

  logic             rx_en_r, tx_en_r;
  logic [RX_CW-1:0] rx_fill_r, rx_fill_nxt;
  logic [TX_CW-1:0] tx_pos_r, tx_pos_nxt;
  logic [TX_CW-1:0] tx_len_r, tx_len_nxt;
  phase_t           rx_phase_r, rx_phase_nxt;
  phase_t           tx_phase_r, tx_phase_nxt;
  logic             ack_r, ack_nxt;
  logic             stage_valid_r;
  stage_t           stage_r, stage_nxt;
  logic             store_rx, read_rx, read_tx, load_tx;
  logic             rxn, txn, fit;
  logic [7:0]       drive;

  always_comb begin
    rx_fill_nxt  = rx_fill_r;
    tx_pos_nxt   = tx_pos_r;
    tx_len_nxt   = tx_len_r;
    rx_phase_nxt = rx_phase_r;
    tx_phase_nxt = tx_phase_r;
    ack_nxt      = ack_r;
    store_rx     = 1'b0;
    read_rx      = 1'b0;
    read_tx      = 1'b0;
    load_tx      = 1'b0;
    rxn          = 1'b0;
    txn          = 1'b0;
    fit          = 1'b0;
    drive        = 8'h00;
    unique case (mode_t'(in_item.mode))
      MODE_WR_ADDR: begin
        rx_fill_nxt  = '0;
        rx_phase_nxt = PH_ACTIVE;
        ack_nxt      = 1'b1;
      end
      MODE_RX_ACK: begin
        if (32'(rx_fill_r) < RX_DEPTH) begin
          store_rx    = 1'b1;
          rx_fill_nxt = rx_fill_r + 1'b1;
        end
        // refuse the next byte once a single free slot is left
        ack_nxt = !((32'(rx_fill_nxt) + 32'd1) >= RX_DEPTH);
      end
      MODE_RX_NACK: begin
        if (32'(rx_fill_r) < RX_DEPTH) begin
          store_rx    = 1'b1;
          rx_fill_nxt = rx_fill_r + 1'b1;
        end
        if (rx_phase_r == PH_ACTIVE) begin
          rx_phase_nxt = PH_DONE;
          rxn          = rx_en_r;
        end
        ack_nxt = 1'b1;
      end
      MODE_STOP: begin
        if (rx_phase_r == PH_ACTIVE) begin
          rx_phase_nxt = PH_DONE;
          rxn          = rx_en_r;
        end
        ack_nxt = 1'b1;
      end
      MODE_RD_ADDR: begin
        tx_phase_nxt = PH_ACTIVE;
        if (tx_len_r != '0) begin
          read_tx    = 1'b1;
          tx_pos_nxt = TX_CW'(1);
        end else begin
          tx_pos_nxt = '0;
          drive      = BYTE_EXHAUSTED;
        end
        txn     = tx_en_r;
        ack_nxt = 1'b1;
      end
      MODE_TX_ACK: begin
        if (tx_pos_r < tx_len_r && 32'(tx_pos_r) < TX_DEPTH) begin
          read_tx    = 1'b1;
          tx_pos_nxt = tx_pos_r + 1'b1;
        end else begin
          drive = BYTE_EXHAUSTED;
        end
        ack_nxt = 1'b1;
      end
      MODE_TX_NACK: begin
        if (tx_phase_r == PH_ACTIVE) begin
          tx_phase_nxt = PH_DONE;
          tx_len_nxt   = '0;
        end
        ack_nxt = 1'b1;
      end
      MODE_BUS_ERR, MODE_OTHER: begin
        ack_nxt = 1'b1;
      end
      MODE_LOAD: begin
        load_tx = (32'(in_item.host_index) < TX_DEPTH);
      end
      MODE_COMMIT: begin
        if (32'(in_item.host_length) <= TX_DEPTH) begin
          tx_len_nxt = TX_CW'(in_item.host_length);
          fit        = 1'b1;
        end else begin
          tx_len_nxt = TX_CW'(TX_DEPTH);
        end
        tx_phase_nxt = PH_IDLE;
      end
      MODE_HOST_RD: begin
        read_rx = (32'(in_item.host_index) < 32'(rx_fill_r)) &&
                  (32'(in_item.host_index) < RX_DEPTH);
      end
      MODE_RELEASE: begin
        rx_phase_nxt = PH_IDLE;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stage_nxt.sel_rx         = read_rx;
    stage_nxt.sel_tx         = read_tx;
    stage_nxt.res.ack_next   = ack_nxt;
    stage_nxt.res.drive_byte = drive;
    stage_nxt.res.rx_done    = (rx_phase_nxt == PH_DONE);
    stage_nxt.res.tx_done    = (tx_phase_nxt == PH_DONE);
    stage_nxt.res.rx_count   = 7'(rx_fill_nxt);
    stage_nxt.res.tx_count   = 7'(tx_pos_nxt);
    stage_nxt.res.host_data  = 8'h00;
    stage_nxt.res.length_fit = fit;
    stage_nxt.res.rx_notify  = rxn;
    stage_nxt.res.tx_notify  = txn;
  end

  assign rx_we    = accept && store_rx;
  assign rx_waddr = RX_AW'(rx_fill_r);
  assign rx_wdata = in_item.bus_byte;
  assign rx_re    = accept && read_rx;
  assign rx_raddr = RX_AW'(in_item.host_index);
  assign tx_we    = accept && load_tx;
  assign tx_waddr = TX_AW'(in_item.host_index);
  assign tx_wdata = in_item.host_byte;
  assign tx_re    = accept && read_tx;
  // read address is the position before this request moves it, or zero for a read address request
  assign tx_raddr = (mode_t'(in_item.mode) == MODE_RD_ADDR) ? '0 : TX_AW'(tx_pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_en_r       <= 1'b0;
      tx_en_r       <= 1'b0;
      rx_fill_r     <= '0;
      tx_pos_r      <= '0;
      tx_len_r      <= '0;
      rx_phase_r    <= PH_IDLE;
      tx_phase_r    <= PH_IDLE;
      ack_r         <= 1'b1;
      stage_valid_r <= 1'b0;
    end else begin
      if (cfg_wr.en) begin
        unique case (cfg_reg_t'(cfg_wr.index))
          CFG_RX_NOTIFY_EN: rx_en_r <= cfg_wr.data[0];
          CFG_TX_NOTIFY_EN: tx_en_r <= cfg_wr.data[0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        rx_fill_r  <= rx_fill_nxt;
        tx_pos_r   <= tx_pos_nxt;
        tx_len_r   <= tx_len_nxt;
        rx_phase_r <= rx_phase_nxt;
        tx_phase_r <= tx_phase_nxt;
        ack_r      <= ack_nxt;
      end
      stage_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_valid = stage_valid_r;
  assign stage       = stage_r;

endmodule

`default_nettype wire

// ===== rtl/i2ctb_back.sv =====
// back end: merges store read data into results and queues them for the host
`default_nettype none

module i2ctb_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 stage_valid,
  input  wire i2ctb_pkg::stage_t    stage,
  input  wire logic [7:0]           rx_rdata,
  input  wire logic [7:0]           tx_rdata,
  input  wire logic                 pop,
  output logic                      empty,
  output i2ctb_pkg::out_item_t      head,
  output logic [i2ctb_pkg::Q_CW-1:0] count
);

  import i2ctb_pkg::*;

  out_item_t        merged;
  out_item_t        q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  count_r, count_nxt;
  logic             do_pop;

  always_comb begin
    merged = stage.res;
    if (stage.sel_rx) begin
      merged.host_data = rx_rdata;
    end
    if (stage.sel_tx) begin
      merged.drive_byte = tx_rdata;
    end
  end

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (stage_valid) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (stage_valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!stage_valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid) begin
      q_mem_r[wr_ptr_r] <= merged;
    end
  end

  assign empty = (count_r == '0);
  assign head  = q_mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

`default_nettype wire

// ===== rtl/i2c_target_buffer_engine.sv =====
// Buffer engine behind an i2c target: bus events and host requests go in
// through a push/full queue port, one result per request comes out through
// an empty/pop queue port in request order. One request is taken every
// clock cycle while the result queue has room. The edge that takes a request
// updates the state, issues the store access and loads the stage register;
// the next edge merges the registered store read and writes the result into
// the queue, whose head drives the out ports. The receive and transmit
// stores each have one write and one read port, so each request touches at
// most one entry of each. The queue holds four results; full is raised once
// four results are waiting or staged. Notify enables are to be written
// through the cfg port only while no request is in flight; the block itself
// does not enforce this. cfg_ready is always high.
`default_nettype none

module i2c_target_buffer_engine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire i2ctb_pkg::in_item_t           in_item,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output i2ctb_pkg::out_item_t               out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [i2ctb_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [i2ctb_pkg::CFG_DW-1:0]  cfg_data
);

  import i2ctb_pkg::*;

  logic             accept;
  cfg_wr_t          cfg_wr;
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [RX_AW-1:0] rx_waddr, rx_raddr;
  logic [TX_AW-1:0] tx_waddr, tx_raddr;
  logic [7:0]       rx_wdata, tx_wdata, rx_rdata, tx_rdata;
  logic             stage_valid;
  stage_t           stage;
  logic [Q_CW-1:0]  q_count;

  // room is counted for the request already sitting in the stage register
  assign in_full   = (32'(q_count) + 32'(stage_valid)) >= Q_DEPTH;
  assign accept    = in_push && !in_full;
  assign cfg_ready = 1'b1;

  assign cfg_wr.en    = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  i2ctb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_item     (in_item),
    .cfg_wr      (cfg_wr),
    .rx_we       (rx_we),
    .rx_waddr    (rx_waddr),
    .rx_wdata    (rx_wdata),
    .rx_re       (rx_re),
    .rx_raddr    (rx_raddr),
    .tx_we       (tx_we),
    .tx_waddr    (tx_waddr),
    .tx_wdata    (tx_wdata),
    .tx_re       (tx_re),
    .tx_raddr    (tx_raddr),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  i2ctb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (rx_wdata),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  i2ctb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  i2ctb_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage_valid),
    .stage       (stage),
    .rx_rdata    (rx_rdata),
    .tx_rdata    (tx_rdata),
    .pop         (out_pop),
    .empty       (out_empty),
    .head        (out_item),
    .count       (q_count)
  );

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(q_count) + 32'(stage_valid)) <= Q_DEPTH)
    else $error("result queue overfilled");

  a_accept_staged: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> stage_valid)
    else $error("accepted request not staged");

  a_one_store_read: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid |-> !(stage.sel_rx && stage.sel_tx))
    else $error("request reads both stores");

  a_rx_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid |-> 32'(stage.res.rx_count) <= RX_DEPTH)
    else $error("receive count beyond buffer depth");

endmodule

`default_nettype wire
